// ----- rtl/core/stq_pkg.sv -----
// Types and codes shared by the sorted timer queue modules.
`timescale 1ns / 1ps
package stq_pkg;

   localparam logic [2:0] ACT_TICK       = 3'd0;
   localparam logic [2:0] ACT_ALLOC      = 3'd1;
   localparam logic [2:0] ACT_FREE       = 3'd2;
   localparam logic [2:0] ACT_INIT       = 3'd3;
   localparam logic [2:0] ACT_ARM        = 3'd4;
   localparam logic [2:0] ACT_CANCEL     = 3'd5;
   localparam logic [2:0] ACT_CANCEL_ALL = 3'd6;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_SWITCH = 2'd2;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;

   localparam logic [31:0] DEADLINE_MAX = 32'hffff_ffff;

   typedef struct packed {
      logic [2:0]  action;
      logic [4:0]  slot;
      logic [31:0] delay;
      logic [3:0]  queue_id;
      logic [31:0] tag;
      logic        auto_cancel;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        ok;
      logic [4:0]  slot_out;
      logic [3:0]  queue_out;
      logic [31:0] tag_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    slot_ok;
      logic    queue_ok;
   } cmd_type;

endpackage

// ----- rtl/core/stq_front.sv -----
// Input stage: range checks on each item and a two-entry command queue.
`timescale 1ns / 1ps
module stq_front #(
   parameter int NUM_TIMERS = 32,
   parameter int NUM_QUEUES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             cmd_valid,
   output stq_pkg::cmd_type cmd,
   input  logic             cmd_pop
);
   import stq_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   cmd_type    entry;

   assign req_stall = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = mem_ff[rp_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      entry.req      = req_data;
      entry.slot_ok  = (req_data.slot != 5'd0) && (7'(req_data.slot) < 7'(NUM_TIMERS));
      entry.queue_ok = 9'(req_data.queue_id) < 9'(NUM_QUEUES);
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= entry;
      end
   end

endmodule

// ----- rtl/core/stq_back.sv -----
// Command sequencer: slot tables, sorted list walks, tick expiry and result register.
`timescale 1ns / 1ps
module stq_back #(
   parameter int NUM_TIMERS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  stq_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic [5:0]       switch_slot,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   localparam int SW = $clog2(NUM_TIMERS);

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_DISP       = 5'd1;
   localparam logic [4:0] S_C0         = 5'd2;
   localparam logic [4:0] S_C_HEAD     = 5'd3;
   localparam logic [4:0] S_C_HEAD2    = 5'd4;
   localparam logic [4:0] S_C_WALK     = 5'd5;
   localparam logic [4:0] S_CDONE      = 5'd6;
   localparam logic [4:0] S_ARM0       = 5'd7;
   localparam logic [4:0] S_ARM_PRE    = 5'd8;
   localparam logic [4:0] S_ARM_WALK   = 5'd9;
   localparam logic [4:0] S_ARM_LINK   = 5'd10;
   localparam logic [4:0] S_ALLOC_SCAN = 5'd11;
   localparam logic [4:0] S_CA_SCAN    = 5'd12;
   localparam logic [4:0] S_TWALK      = 5'd13;
   localparam logic [4:0] S_TEND       = 5'd14;
   localparam logic [4:0] S_TSW        = 5'd15;
   localparam logic [4:0] S_REPLY      = 5'd16;

   logic [4:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic [SW-1:0] prv_ff, prv_in;
   logic [SW-1:0] lsave_ff, lsave_in;
   logic [SW-1:0] head_ff, head_in;
   logic [31:0]   earliest_ff, earliest_in;
   logic [31:0]   count_ff, count_in;
   logic          ok_ff, ok_in;
   logic          ran_ff, ran_in;
   logic          ts_ff, ts_in;
   rsp_type       pend_ff, pend_in;
   logic          pend_v_ff, pend_v_in;
   logic          rsp_v_ff, rsp_v_in;
   rsp_type       rsp_ff, rsp_in;

   logic [1:0]    status_ff [NUM_TIMERS];
   logic          ac_ff [NUM_TIMERS];
   logic [31:0]   deadline_mem [NUM_TIMERS];
   logic [SW-1:0] link_mem [NUM_TIMERS];
   logic [3:0]    queue_mem [NUM_TIMERS];
   logic [31:0]   tag_mem [NUM_TIMERS];

   logic          st_we;
   logic [SW-1:0] st_wa;
   logic [1:0]    st_wd;
   logic          ac_we, ac_wd;
   logic          ln_we;
   logic [SW-1:0] ln_wa, ln_wd;
   logic          dl_we, init_we;

   logic          out_free, emit;
   rsp_type       emit_data;
   logic [1:0]    st_idx;
   logic [SW-1:0] link_cur, link_idx;
   logic [31:0]   dl_cur, dnew;
   logic          last_idx, due, is_sw;
   rsp_type       event_item, switch_item, reply_item;

   assign out_free  = !rsp_v_ff || !rsp_stall;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   assign st_idx   = status_ff[idx_ff];
   assign link_cur = (cur_ff == '0) ? '0 : link_mem[cur_ff];
   assign link_idx = link_mem[idx_ff];
   assign dl_cur   = (cur_ff == '0) ? DEADLINE_MAX : deadline_mem[cur_ff];
   assign dnew     = cmd_ff.req.delay + count_ff;
   assign last_idx = (idx_ff == SW'(NUM_TIMERS - 1));
   assign due      = (cur_ff != '0) && !(dl_cur > count_ff);
   assign is_sw    = (7'(switch_slot) == 7'(cur_ff));

   always_comb begin
      event_item           = '0;
      event_item.kind      = KIND_EXPIRY;
      event_item.slot_out  = 5'(cur_ff);
      event_item.queue_out = queue_mem[cur_ff];
      event_item.tag_out   = tag_mem[cur_ff];
      switch_item          = '0;
      switch_item.kind     = KIND_SWITCH;
      switch_item.slot_out = switch_slot[4:0];
      switch_item.last     = 1'b1;
      reply_item           = '0;
      reply_item.kind      = KIND_REPLY;
      reply_item.ok        = ok_ff;
      reply_item.slot_out  = (cmd_ff.req.action == ACT_ALLOC && ok_ff) ? 5'(idx_ff) : 5'd0;
      reply_item.last      = 1'b1;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      cur_in      = cur_ff;
      prv_in      = prv_ff;
      lsave_in    = lsave_ff;
      head_in     = head_ff;
      earliest_in = earliest_ff;
      count_in    = count_ff;
      ok_in       = ok_ff;
      ran_in      = ran_ff;
      ts_in       = ts_ff;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      emit_data   = reply_item;
      st_we       = 1'b0;
      st_wa       = idx_ff;
      st_wd       = ST_FREE;
      ac_we       = 1'b0;
      ac_wd       = 1'b0;
      ln_we       = 1'b0;
      ln_wa       = idx_ff;
      ln_wd       = head_ff;
      dl_we       = 1'b0;
      init_we     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               ok_in    = 1'b0;
               ts_in    = 1'b0;
               ran_in   = 1'b0;
               state_in = S_DISP;
               if (cmd.req.action == ACT_ALLOC) begin
                  idx_in = '0;
               end else if (cmd.req.action == ACT_CANCEL_ALL) begin
                  idx_in = SW'(1);
               end else begin
                  idx_in = SW'(cmd.req.slot);
               end
            end
         end
         S_DISP: begin
            case (cmd_ff.req.action)
               ACT_TICK: begin
                  count_in = count_ff + 32'd1;
                  cur_in   = head_ff;
                  state_in = (earliest_ff > count_ff + 32'd1) ? S_IDLE : S_TWALK;
               end
               ACT_ALLOC: state_in = S_ALLOC_SCAN;
               ACT_FREE, ACT_ARM, ACT_CANCEL: begin
                  state_in = cmd_ff.slot_ok ? S_C0 : S_REPLY;
               end
               ACT_INIT: begin
                  if (cmd_ff.slot_ok && cmd_ff.queue_ok) begin
                     init_we = 1'b1;
                     ac_we   = 1'b1;
                     ac_wd   = cmd_ff.req.auto_cancel;
                     ok_in   = 1'b1;
                  end
                  state_in = S_REPLY;
               end
               ACT_CANCEL_ALL: state_in = S_CA_SCAN;
               default: state_in = S_REPLY;
            endcase
         end
         S_C0: begin
            ran_in   = (st_idx == ST_RUN);
            lsave_in = link_idx;
            cur_in   = head_ff;
            if (st_idx == ST_RUN) begin
               state_in = (head_ff == idx_ff) ? S_C_HEAD : S_C_WALK;
            end else if (cmd_ff.req.action == ACT_ARM && st_idx == ST_FREE) begin
               state_in = S_REPLY;
            end else begin
               state_in = S_CDONE;
            end
         end
         S_C_HEAD: begin
            head_in  = lsave_ff;
            cur_in   = lsave_ff;
            state_in = S_C_HEAD2;
         end
         S_C_HEAD2: begin
            earliest_in = dl_cur;
            state_in    = S_CDONE;
         end
         S_C_WALK: begin
            if (link_cur == idx_ff) begin
               ln_we    = 1'b1;
               ln_wa    = cur_ff;
               ln_wd    = lsave_ff;
               state_in = S_CDONE;
            end else begin
               cur_in = link_cur;
            end
         end
         S_CDONE: begin
            case (cmd_ff.req.action)
               ACT_FREE: begin
                  st_we    = 1'b1;
                  st_wd    = ST_FREE;
                  ok_in    = 1'b1;
                  state_in = S_REPLY;
               end
               ACT_CANCEL: begin
                  st_we    = ran_ff;
                  st_wd    = ST_ALLOC;
                  ok_in    = ran_ff;
                  state_in = S_REPLY;
               end
               ACT_ARM: state_in = S_ARM0;
               ACT_CANCEL_ALL: begin
                  st_we = 1'b1;
                  st_wd = ST_FREE;
                  ok_in = 1'b1;
                  if (last_idx) begin
                     state_in = S_REPLY;
                  end else begin
                     idx_in   = idx_ff + SW'(1);
                     state_in = S_CA_SCAN;
                  end
               end
               default: state_in = S_REPLY;
            endcase
         end
         S_ARM0: begin
            dl_we = 1'b1;
            st_we = 1'b1;
            st_wd = ST_RUN;
            if (dnew <= earliest_ff) begin
               ln_we       = 1'b1;
               ln_wa       = idx_ff;
               ln_wd       = head_ff;
               head_in     = idx_ff;
               earliest_in = dnew;
               ok_in       = 1'b1;
               state_in    = S_REPLY;
            end else begin
               cur_in   = head_ff;
               state_in = S_ARM_PRE;
            end
         end
         S_ARM_PRE: begin
            prv_in   = cur_ff;
            cur_in   = link_cur;
            state_in = S_ARM_WALK;
         end
         S_ARM_WALK: begin
            if (cur_ff == '0 || dnew <= dl_cur) begin
               ln_we    = 1'b1;
               ln_wa    = prv_ff;
               ln_wd    = idx_ff;
               state_in = S_ARM_LINK;
            end else begin
               prv_in = cur_ff;
               cur_in = link_cur;
            end
         end
         S_ARM_LINK: begin
            ln_we    = 1'b1;
            ln_wa    = idx_ff;
            ln_wd    = cur_ff;
            ok_in    = 1'b1;
            state_in = S_REPLY;
         end
         S_ALLOC_SCAN: begin
            if (st_idx == ST_FREE) begin
               st_we    = 1'b1;
               st_wd    = ST_ALLOC;
               ac_we    = 1'b1;
               ac_wd    = 1'b0;
               ok_in    = 1'b1;
               state_in = S_REPLY;
            end else if (last_idx) begin
               state_in = S_REPLY;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         S_CA_SCAN: begin
            if (st_idx != ST_FREE && ac_ff[idx_ff] &&
                queue_mem[idx_ff] == cmd_ff.req.queue_id) begin
               state_in = S_C0;
            end else if (last_idx) begin
               state_in = S_REPLY;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         S_TWALK: begin
            if (!due) begin
               head_in     = cur_ff;
               earliest_in = dl_cur;
               state_in    = S_TEND;
            end else if (is_sw) begin
               st_we  = 1'b1;
               st_wa  = cur_ff;
               st_wd  = ST_ALLOC;
               ts_in  = 1'b1;
               cur_in = link_cur;
            end else if (!pend_v_ff || out_free) begin
               emit      = pend_v_ff;
               emit_data = pend_ff;
               pend_in   = event_item;
               pend_v_in = 1'b1;
               st_we     = 1'b1;
               st_wa     = cur_ff;
               st_wd     = ST_ALLOC;
               cur_in    = link_cur;
            end
         end
         S_TEND: begin
            if (!pend_v_ff) begin
               state_in = ts_ff ? S_TSW : S_IDLE;
            end else if (out_free) begin
               emit           = 1'b1;
               emit_data      = pend_ff;
               emit_data.last = !ts_ff;
               pend_v_in      = 1'b0;
               state_in       = ts_ff ? S_TSW : S_IDLE;
            end
         end
         S_TSW: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = switch_item;
               state_in  = S_IDLE;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = reply_item;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_v_in = emit || (rsp_v_ff && rsp_stall);
      rsp_in   = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         earliest_ff <= DEADLINE_MAX;
         count_ff    <= '0;
         pend_v_ff   <= 1'b0;
         rsp_v_ff    <= 1'b0;
         ok_ff       <= 1'b0;
         ran_ff      <= 1'b0;
         ts_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         earliest_ff <= earliest_in;
         count_ff    <= count_in;
         pend_v_ff   <= pend_v_in;
         rsp_v_ff    <= rsp_v_in;
         ok_ff       <= ok_in;
         ran_ff      <= ran_in;
         ts_ff       <= ts_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      cur_ff   <= cur_in;
      prv_ff   <= prv_in;
      lsave_ff <= lsave_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            status_ff[i] <= (i == 0) ? ST_RUN : ST_FREE;
            ac_ff[i]     <= 1'b0;
         end
      end else begin
         if (st_we) begin
            status_ff[st_wa] <= st_wd;
         end
         if (ac_we) begin
            ac_ff[idx_ff] <= ac_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ln_we) begin
         link_mem[ln_wa] <= ln_wd;
      end
      if (dl_we) begin
         deadline_mem[idx_ff] <= dnew;
      end
      if (init_we) begin
         queue_mem[idx_ff] <= cmd_ff.req.queue_id;
         tag_mem[idx_ff]   <= cmd_ff.req.tag;
      end
   end

endmodule

// ----- rtl/core/sorted_timer_queue_core.sv -----
// Sorted timer queue top level: switch slot register, command queue and sequencer.
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  stq_pkg::req_type
//  rsp_      out        rsp_valid/rsp_stall  stq_pkg::rsp_type
//  csr_      in         csr_we               switch slot, 6 bits
//
// init and bad commands go straight to the reply; arm, cancel and free may walk
// the sorted list, one linked slot a cycle; alloc and cancel_all scan the slot
// table one slot a cycle, cancel_all adding a list walk per slot hit. A tick
// walks the due slots from the head of the list.
// Reset is synchronous; the slot tables need no clearing pass.
// A two-entry command queue takes items while a result waits on rsp_stall.
`timescale 1ns / 1ps
module sorted_timer_queue_core #(
   parameter int NUM_TIMERS = 32,
   parameter int NUM_QUEUES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [5:0]       csr_wdata
);
   import stq_pkg::*;

   logic [5:0] switch_ff;
   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_ff <= 6'd32;
      end else if (csr_we) begin
         switch_ff <= csr_wdata;
      end
   end

   stq_front #(
      .NUM_TIMERS (NUM_TIMERS),
      .NUM_QUEUES (NUM_QUEUES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   stq_back #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .switch_slot (switch_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- rtl/core/stq_checker.sv -----
// Port checker for the sorted timer queue, bound to the top level.
`timescale 1ns / 1ps
module stq_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_REPLY |->
         rsp_data.last && rsp_data.queue_out == 4'd0 && rsp_data.tag_out == 32'd0)
      else $error("command reply malformed");

   a_switch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_SWITCH |-> rsp_data.last && !rsp_data.ok)
      else $error("switch request not final");

   a_event_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.kind == KIND_EXPIRY && !rsp_data.last
         |=> !(rsp_valid && rsp_data.kind == KIND_REPLY))
      else $error("expiry run not closed before next reply");

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
